// ----- rtl/spq_pkg.sv -----
// Shared types, constants and address helper for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Sizes
    localparam int DEPTH       = 16;
    localparam int PRIO_BITS   = 16;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS    = 5;
    localparam int CFG_BITS    = 5;
    localparam int STATUS_BITS = 2;
    localparam int ENTRY_BITS  = PRIO_BITS + DATA_BITS;

    // Capacity register value after reset
    localparam logic [CFG_BITS-1:0] MAX_RESET = CFG_BITS'(16);

    // Request operations
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Response status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                 op;
        logic [PRIO_BITS-1:0] item_priority;
        logic [DATA_BITS-1:0] item_payload;
    } t_req;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [PRIO_BITS-1:0]   head_priority;
        logic [DATA_BITS-1:0]   head_payload;
        logic [CNT_BITS-1:0]    entry_count;
    } t_rsp;

    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [DATA_BITS-1:0] data;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_PUT,
        S_RDH,
        S_HEAD,
        S_DONE
    } t_state;

    // Circular buffer: physical slot of a logical position behind the head
    function automatic logic [ADDR_BITS-1:0] slot_addr(
        input logic [ADDR_BITS-1:0] head,
        input logic [ADDR_BITS-1:0] pos
    );
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (ADDR_BITS+1)'(DEPTH)) begin
            sum = sum - (ADDR_BITS+1)'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

// ----- rtl/spq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spq_core.sv -----
// Sequencer and shared priority comparator that keep the entry RAM sorted.
`timescale 1ns / 1ps

module spq_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  spq_pkg::t_req                i_req,
    input  logic [spq_pkg::CFG_BITS-1:0] i_max_entries,
    input  logic                         i_rsp_free,
    output logic                         o_busy,
    output logic                         o_done,
    output spq_pkg::t_rsp                o_rsp
);

    import spq_pkg::*;

    t_state               r_state, n_state;
    logic [ADDR_BITS-1:0] r_head, n_head;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [CNT_BITS-1:0]  r_idx, n_idx;
    t_req                 r_req, n_req;
    t_rsp                 r_rsp, n_rsp;

    logic                 w_we;
    logic [ADDR_BITS-1:0] w_waddr;
    t_entry               w_wdata;
    logic [ADDR_BITS-1:0] w_raddr;
    t_entry               w_rdata;
    logic [CNT_BITS-1:0]  w_cap;
    logic                 w_full;
    logic                 w_lower;
    logic [CNT_BITS-1:0]  w_idx_m1;
    t_entry               w_new;

    // Capacity in use, clipped to the RAM depth
    assign w_cap  = (i_max_entries > CFG_BITS'(DEPTH)) ? CNT_BITS'(DEPTH)
                                                       : CNT_BITS'(i_max_entries);
    assign w_full = (r_count >= w_cap);

    // The one comparator: stored entry strictly below the new priority
    assign w_lower  = (w_rdata.prio < r_req.item_priority);
    assign w_idx_m1 = r_idx - CNT_BITS'(1);
    assign w_new    = '{prio: r_req.item_priority, data: r_req.item_payload};

    spq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req.op == OP_REMOVE) begin
                        n_state = (r_count == '0) ? S_DONE : S_RDH;
                    end else if (w_full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = (r_count == '0) ? S_PUT : S_READ;
                    end
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (w_lower) begin
                    n_state = (r_idx == CNT_BITS'(1)) ? S_PUT : S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PUT:  n_state = S_DONE;
            S_RDH:  n_state = S_HEAD;
            S_HEAD: n_state = S_DONE;
            S_DONE: begin
                if (i_rsp_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM control and register updates
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_idx   = r_idx;
        n_req   = r_req;
        n_rsp   = r_rsp;
        w_we    = 1'b0;
        w_waddr = slot_addr(r_head, r_idx[ADDR_BITS-1:0]);
        w_wdata = w_new;
        w_raddr = slot_addr(r_head, w_idx_m1[ADDR_BITS-1:0]);
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_idx = r_count;
                    n_rsp = '0;
                    if (i_req.op == OP_REMOVE) begin
                        if (r_count == '0) begin
                            n_rsp.status = ST_EMPTY;
                        end
                    end else if (w_full) begin
                        n_rsp.status = ST_FULL;
                    end
                end
            end
            S_READ: begin
                // read address already set to logical idx-1
            end
            S_CMP: begin
                w_we = 1'b1;
                if (w_lower) begin
                    // move the lower entry one place toward the tail
                    w_wdata = w_rdata;
                    n_idx   = w_idx_m1;
                end else begin
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_head;
                n_count = r_count + CNT_BITS'(1);
            end
            S_RDH: begin
                w_raddr = r_head;
            end
            S_HEAD: begin
                n_rsp.head_priority = w_rdata.prio;
                n_rsp.head_payload  = w_rdata.data;
                n_head  = slot_addr(r_head, ADDR_BITS'(1));
                n_count = r_count - CNT_BITS'(1);
            end
            S_DONE: begin
                o_done = i_rsp_free;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_rsp             = r_rsp;
        o_rsp.entry_count = r_count;
    end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue top level: capacity register, core and output register.
//
// Input channel: i_in_valid / o_in_stall carry one request (insert or
// remove) in i_in_req. A request is taken at a clock edge with valid high
// and stall low. Output channel: o_out_valid / i_out_stall carry one
// response in o_out_rsp for every request, in request order.
// Entries live in a circular RAM of DEPTH slots kept sorted highest first.
// A remove reads the head slot, captures the entry and then responds.
// An insert walks backward from the tail with one comparator and one RAM
// read per step; each entry with strictly lower priority is moved one slot
// toward the tail. The new entry lands behind the first entry that is not
// lower, else at the head. Refused requests go straight to the response.
// The registered RAM read makes each step a read followed by a compare.
// o_in_stall is high while a request is in progress.
// The response sits in an output register; a stalled receiver holds it
// and the next request may be taken meanwhile, finishing once the
// register frees up. Reset empties the queue and sets the capacity to 16.
// i_cfg_we writes the capacity from i_cfg_wdata; write only when idle.
`timescale 1ns / 1ps

module sorted_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  spq_pkg::t_req                i_in_req,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output spq_pkg::t_rsp                o_out_rsp,
    input  logic                         i_cfg_we,
    input  logic [spq_pkg::CFG_BITS-1:0] i_cfg_wdata
);

    import spq_pkg::*;

    logic [CFG_BITS-1:0] r_max_entries;
    logic                r_out_valid;
    t_rsp                r_out_rsp;
    logic                w_busy;
    logic                w_done;
    logic                w_rsp_free;
    t_rsp                w_rsp;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_RESET;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    assign w_rsp_free = !r_out_valid || !i_out_stall;

    spq_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_in_valid),
        .i_req         (i_in_req),
        .i_max_entries (r_max_entries),
        .i_rsp_free    (w_rsp_free),
        .o_busy        (w_busy),
        .o_done        (w_done),
        .o_rsp         (w_rsp)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_rsp <= w_rsp;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule
